// ----- hw/rtl/rflog_pkg.sv -----
package rflog_pkg;

  localparam int DEPTH     = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int TERM_BITS = 32;

  typedef logic [TERM_BITS-1:0] term_t;
  typedef logic [63:0]          payload_t;
  typedef logic [IDX_W-1:0]     slot_t;

  // status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_PREV_MIS = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_GAP      = 2'd3;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_APPLY  = 1'b1;

endpackage

// ----- hw/rtl/raft_follower_log_append_core.sv -----
// Follower log append. A reject (index out of range, previous term mismatch) gives its status
// result from the previous-entry check; a store gives it after the conflict check, the clearing
// of a conflicting run of entries on a term conflict, and the store. Apply results then follow
// one per cycle (one payload memory read per cycle); a new entry is accepted only while idle.
// Receiver cannot stall; each result is shown for exactly one cycle on out_strobe.
// Reset (synchronous, rst_n low): valid marks cleared, next index 0, commit index -1.
module raft_follower_log_append_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [5:0]          in_entry_index,
  input  logic [31:0]         in_entry_term,
  input  logic [63:0]         in_entry_payload,
  input  logic [31:0]         in_prev_term,
  input  logic signed [6:0]   in_leader_commit,
  output logic                out_strobe,
  output logic                out_result_kind,
  output logic [1:0]          out_status,
  output logic [5:0]          out_next_expected,
  output logic [4:0]          out_apply_index,
  output logic [63:0]         out_apply_payload,
  output logic                out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHKP, S_CHKC, S_CLR, S_STORE, S_STAT, S_APPLY
  } state_t;

  state_t state_r;

  // log store
  rflog_pkg::term_t    term_mem    [rflog_pkg::DEPTH];
  rflog_pkg::payload_t payload_mem [rflog_pkg::DEPTH];
  logic [rflog_pkg::DEPTH-1:0] valid_r;

  rflog_pkg::term_t    term_rd_r;
  rflog_pkg::payload_t pay_rd_r;
  rflog_pkg::slot_t    term_raddr;
  rflog_pkg::slot_t    pay_raddr;
  logic                mem_we;

  // captured transaction
  logic [5:0]          idx_r;
  rflog_pkg::term_t    term_r;
  rflog_pkg::payload_t pay_r;
  rflog_pkg::term_t    ptrm_r;
  logic signed [6:0]   lc_r;

  logic [5:0]          next_r;
  logic signed [6:0]   commit_r;
  logic [5:0]          clr_r;
  rflog_pkg::slot_t    ci_r;

  logic                out_strobe_r;
  logic                out_kind_r;
  logic [1:0]          out_status_r;
  logic [5:0]          out_next_r;
  logic [4:0]          out_idx_r;
  logic [63:0]         out_pay_r;
  logic                out_last_r;

  logic                accept;
  rflog_pkg::slot_t    slot;
  rflog_pkg::slot_t    prev_slot;
  logic signed [6:0]   idx_s;
  logic signed [6:0]   target;
  logic signed [6:0]   commit_p1;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign slot      = idx_r[rflog_pkg::IDX_W-1:0];
  assign prev_slot = slot - rflog_pkg::slot_t'(1);
  assign idx_s     = signed'({1'b0, idx_r});
  assign target    = (lc_r < idx_s) ? lc_r : idx_s;
  assign commit_p1 = commit_r + 7'sd1;
  assign mem_we    = (state_r == S_STORE);

  always_comb begin
    term_raddr = slot;
    if (state_r == S_IDLE) begin
      term_raddr = in_entry_index[rflog_pkg::IDX_W-1:0] - rflog_pkg::slot_t'(1);
    end
    pay_raddr = ci_r + rflog_pkg::slot_t'(1);
    if (state_r == S_STAT) begin
      pay_raddr = commit_p1[rflog_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      term_mem[slot]    <= term_r;
      payload_mem[slot] <= pay_r;
    end
    term_rd_r <= term_mem[term_raddr];
    pay_rd_r  <= payload_mem[pay_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      next_r       <= '0;
      commit_r     <= -7'sd1;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r   <= in_entry_index;
            term_r  <= in_entry_term[rflog_pkg::TERM_BITS-1:0];
            pay_r   <= in_entry_payload;
            ptrm_r  <= in_prev_term[rflog_pkg::TERM_BITS-1:0];
            lc_r    <= in_leader_commit;
            state_r <= S_CHKP;
          end
        end
        S_CHKP: begin
          // term_rd_r holds the predecessor term here
          if (idx_r >= 6'(rflog_pkg::DEPTH)) begin
            out_strobe_r <= 1'b1;
            out_kind_r   <= rflog_pkg::KIND_STATUS;
            out_status_r <= rflog_pkg::ST_RANGE;
            out_next_r   <= next_r;
            out_idx_r    <= '0;
            out_pay_r    <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else if (slot != '0 && (!valid_r[prev_slot] || term_rd_r != ptrm_r)) begin
            next_r       <= {1'b0, prev_slot};
            out_strobe_r <= 1'b1;
            out_kind_r   <= rflog_pkg::KIND_STATUS;
            out_status_r <= rflog_pkg::ST_PREV_MIS;
            out_next_r   <= {1'b0, prev_slot};
            out_idx_r    <= '0;
            out_pay_r    <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_CHKC;
          end
        end
        S_CHKC: begin
          if (valid_r[slot] && term_rd_r != term_r) begin
            next_r  <= idx_r;
            clr_r   <= idx_r;
            state_r <= S_CLR;
          end else begin
            state_r <= S_STORE;
          end
        end
        S_CLR: begin
          // drop the run of valid entries starting at the conflict
          if (clr_r < 6'(rflog_pkg::DEPTH) && valid_r[clr_r[rflog_pkg::IDX_W-1:0]]) begin
            valid_r[clr_r[rflog_pkg::IDX_W-1:0]] <= 1'b0;
            clr_r <= clr_r + 6'd1;
          end else begin
            state_r <= S_STORE;
          end
        end
        S_STORE: begin
          valid_r[slot] <= 1'b1;
          if (idx_r >= next_r) begin
            next_r <= idx_r + 6'd1;
          end
          state_r <= S_STAT;
        end
        S_STAT: begin
          out_strobe_r <= 1'b1;
          out_kind_r   <= rflog_pkg::KIND_STATUS;
          out_status_r <= rflog_pkg::ST_ACCEPTED;
          out_next_r   <= next_r;
          out_idx_r    <= '0;
          out_pay_r    <= '0;
          if (target > commit_r) begin
            out_last_r <= 1'b0;
            ci_r       <= commit_p1[rflog_pkg::IDX_W-1:0];
            state_r    <= S_APPLY;
          end else begin
            out_last_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        S_APPLY: begin
          // pay_rd_r holds the payload at ci_r
          out_strobe_r <= 1'b1;
          out_kind_r   <= rflog_pkg::KIND_APPLY;
          out_next_r   <= next_r;
          out_idx_r    <= ci_r;
          if (!valid_r[ci_r]) begin
            out_status_r <= rflog_pkg::ST_GAP;
            out_pay_r    <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            out_status_r <= rflog_pkg::ST_ACCEPTED;
            out_pay_r    <= pay_rd_r;
            commit_r     <= signed'({2'b00, ci_r});
            if (ci_r == target[rflog_pkg::IDX_W-1:0]) begin
              out_last_r <= 1'b1;
              state_r    <= S_IDLE;
            end else begin
              out_last_r <= 1'b0;
              ci_r       <= ci_r + rflog_pkg::slot_t'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_result_kind   = out_kind_r;
  assign out_status        = out_status_r;
  assign out_next_expected = out_next_r;
  assign out_apply_index   = out_idx_r;
  assign out_apply_payload = out_pay_r;
  assign out_last          = out_last_r;

endmodule
